// ===== rtl/cmcmf_pkg.sv =====
// ----------------------------------------------------------------------------
// cmcmf_pkg
// shared types and constants for the multi-channel message fifo
// ----------------------------------------------------------------------------
`default_nettype none
package cmcmf_pkg;
    localparam int unsigned CHANNELS_DEF  = 4;
    localparam int unsigned SLOTS_DEF     = 8;
    localparam int unsigned MSG_BYTES_DEF = 256;

    localparam logic [1:0] CMD_WRITE = 2'd0;
    localparam logic [1:0] CMD_READ  = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;
    localparam logic [1:0] CMD_NOP   = 2'd3;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_FULL     = 3'd1;
    localparam logic [2:0] ST_EMPTY    = 3'd2;
    localparam logic [2:0] ST_BAD_CH   = 3'd3;
    localparam logic [2:0] ST_TOO_LONG = 3'd4;

    typedef struct packed {
        logic [1:0] cmd;
        logic [1:0] channel;
        logic [7:0] data_in;
        logic       last_in;
    } t_item;

    typedef struct packed {
        logic [2:0] status;
        logic [7:0] data_out;
        logic       last_out;
        logic [8:0] msg_length;
    } t_result;
endpackage
`default_nettype wire

// ===== rtl/cmcmf_ram.sv =====
// ----------------------------------------------------------------------------
// cmcmf_ram
// generic single-port-write, single-port-read ram with registered read
// ----------------------------------------------------------------------------
`default_nettype none
module cmcmf_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule
`default_nettype wire

// ===== rtl/cmcmf_front.sv =====
// ----------------------------------------------------------------------------
// cmcmf_front
// input stage and short queue of accepted transactions
// ----------------------------------------------------------------------------
`default_nettype none
module cmcmf_front
    import cmcmf_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_valid,
    output logic       o_stall,
    input  wire t_item i_item,
    output logic       o_valid,
    input  wire logic  i_take,
    output t_item      o_item
);
    t_item      r_q [2];
    logic [1:0] r_cnt;
    logic       r_rd;
    logic       w_push;
    logic       w_pop;

    assign o_stall = (r_cnt == 2'd2);
    assign w_push  = i_valid && !o_stall;
    assign o_valid = (r_cnt != 2'd0);
    assign w_pop   = o_valid && i_take;
    assign o_item  = r_q[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
            r_rd  <= 1'b0;
        end else begin
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
            if (w_pop) begin
                r_rd <= !r_rd;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_rd ^ (r_cnt == 2'd1)] <= i_item;
        end
    end
endmodule
`default_nettype wire

// ===== rtl/cmcmf_back.sv =====
// ----------------------------------------------------------------------------
// cmcmf_back
// executes one transaction at a time: state update, then for non-empty reads a length ram read and a byte ram read
// ----------------------------------------------------------------------------
`default_nettype none
module cmcmf_back
    import cmcmf_pkg::*;
#(
    parameter int unsigned CHANNELS  = CHANNELS_DEF,
    parameter int unsigned SLOTS     = SLOTS_DEF,
    parameter int unsigned MSG_BYTES = MSG_BYTES_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_valid,
    output logic       o_take,
    input  wire t_item i_item,
    output logic       o_valid,
    input  wire logic  i_stall,
    output t_result    o_result
);
    localparam int unsigned CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int unsigned SW = $clog2(SLOTS);
    localparam int unsigned OW = $clog2(MSG_BYTES);
    localparam int unsigned WOW = $clog2(MSG_BYTES + 2);
    localparam int unsigned QW = $clog2(SLOTS + 1);
    localparam int unsigned BDEPTH = 1 << (CW + SW + OW);
    localparam int unsigned LDEPTH = 1 << (CW + SW);
    localparam int unsigned BAW = $clog2(BDEPTH);
    localparam int unsigned LAW = $clog2(LDEPTH);
    localparam int unsigned LW = $clog2(MSG_BYTES + 2);

    logic [SW-1:0]  r_head [CHANNELS];
    logic [SW-1:0]  r_tail [CHANNELS];
    logic [QW-1:0]  r_qcnt [CHANNELS];
    logic [WOW-1:0] r_woff [CHANNELS];
    logic [OW:0]    r_roff [CHANNELS];
    logic           r_rej  [CHANNELS];

    // two-step read: lengths ram first, bytes ram second
    logic          r_busy;
    logic [1:0]    r_phase;
    t_item         r_it;
    logic          r_ovalid;
    t_result       r_res;
    logic [LW-1:0] r_len;
    logic          r_dzero;
    logic          r_rlast;

    logic [CW-1:0] w_ch;
    logic          w_badch;
    logic          w_start;
    logic [LW-1:0] w_len_rd;
    logic [7:0]    w_byte_rd;
    logic          w_bwe;
    logic [BAW-1:0] w_bwaddr;
    logic          w_lwe;
    logic [LAW-1:0] w_lwaddr;
    logic [LW-1:0]  w_lwdata;
    logic [LAW-1:0] w_lraddr;
    logic [BAW-1:0] w_braddr;
    logic           w_bre;
    logic [OW:0]    w_off;
    logic           w_last;

    assign w_ch    = r_it.channel[CW-1:0];
    assign w_badch = ({30'd0, r_it.channel} >= 32'(CHANNELS));
    assign o_take  = !r_busy && !(r_ovalid && i_stall);
    assign w_start = i_valid && o_take;
    assign o_valid = r_ovalid;
    assign o_result = r_res;

    cmcmf_ram #(.WIDTH(LW), .DEPTH(LDEPTH)) u_len (
        .i_clk  (i_clk),
        .i_we   (w_lwe),
        .i_waddr(w_lwaddr),
        .i_wdata(w_lwdata),
        .i_re   (1'b1),
        .i_raddr(w_lraddr),
        .o_rdata(w_len_rd)
    );

    cmcmf_ram #(.WIDTH(8), .DEPTH(BDEPTH)) u_bytes (
        .i_clk  (i_clk),
        .i_we   (w_bwe),
        .i_waddr(w_bwaddr),
        .i_wdata(r_it.data_in),
        .i_re   (w_bre),
        .i_raddr(w_braddr),
        .o_rdata(w_byte_rd)
    );

    assign w_lraddr = LAW'({w_ch, r_head[w_ch]});
    assign w_off    = r_roff[w_ch];
    assign w_braddr = BAW'({w_ch, r_head[w_ch], w_off[OW-1:0]});
    assign w_bre    = r_busy && (r_phase == 2'd1);
    assign w_last   = ({{(32-OW-1){1'b0}}, w_off} + 32'd1) >= {{(32-LW){1'b0}}, w_len_rd};

    always_comb begin
        w_bwe    = 1'b0;
        w_lwe    = 1'b0;
        w_bwaddr = BAW'({w_ch, r_tail[w_ch], r_woff[w_ch][OW-1:0]});
        w_lwaddr = LAW'({w_ch, r_tail[w_ch]});
        w_lwdata = LW'(r_woff[w_ch] + WOW'(1));
        if (r_busy && r_phase == 2'd0 && r_it.cmd == CMD_WRITE && !w_badch) begin
            w_bwe = (32'(r_qcnt[w_ch]) < 32'(SLOTS)) &&
                    (32'(r_woff[w_ch]) < 32'(MSG_BYTES));
            w_lwe = r_it.last_in && (32'(r_qcnt[w_ch]) < 32'(SLOTS)) && !r_rej[w_ch] &&
                    (32'(r_woff[w_ch]) < 32'(MSG_BYTES));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_phase  <= 2'd0;
            r_ovalid <= 1'b0;
            for (int c = 0; c < CHANNELS; c++) begin
                r_head[c] <= '0;
                r_tail[c] <= '0;
                r_qcnt[c] <= '0;
                r_woff[c] <= '0;
                r_roff[c] <= '0;
                r_rej[c]  <= 1'b0;
            end
        end else begin
            if (r_ovalid && !i_stall) begin
                r_ovalid <= 1'b0;
            end
            if (w_start) begin
                r_busy  <= 1'b1;
                r_phase <= 2'd0;
                r_it    <= i_item;
            end else if (r_busy) begin
                case (r_phase)
                    2'd0: begin
                        t_result res;
                        res = '0;
                        if (r_it.cmd == CMD_NOP) begin
                            r_busy <= 1'b0; r_ovalid <= 1'b1;
                        end else if (w_badch) begin
                            res.status = ST_BAD_CH;
                            r_busy <= 1'b0; r_ovalid <= 1'b1;
                        end else if (r_it.cmd == CMD_CLEAR) begin
                            r_head[w_ch] <= '0; r_tail[w_ch] <= '0;
                            r_qcnt[w_ch] <= '0; r_woff[w_ch] <= '0;
                            r_roff[w_ch] <= '0; r_rej[w_ch] <= 1'b0;
                            r_busy <= 1'b0; r_ovalid <= 1'b1;
                        end else if (r_it.cmd == CMD_WRITE) begin
                            logic full;
                            logic tlong;
                            logic [WOW-1:0] noff;
                            full  = 32'(r_qcnt[w_ch]) >= 32'(SLOTS);
                            tlong = 32'(r_woff[w_ch]) >= 32'(MSG_BYTES);
                            noff  = (32'(r_woff[w_ch]) <= 32'(MSG_BYTES)) ?
                                    r_woff[w_ch] + WOW'(1) : r_woff[w_ch];
                            if (!r_it.last_in) begin
                                r_woff[w_ch] <= noff;
                                if (full) r_rej[w_ch] <= 1'b1;
                                res.status = full ? ST_FULL :
                                             (tlong ? ST_TOO_LONG : ST_OK);
                            end else begin
                                if (full || r_rej[w_ch]) begin
                                    res.status = ST_FULL;
                                end else if (32'(noff) > 32'(MSG_BYTES)) begin
                                    res.status = ST_TOO_LONG;
                                end else begin
                                    r_tail[w_ch] <= (r_tail[w_ch] == SW'(SLOTS - 1)) ?
                                                    '0 : r_tail[w_ch] + SW'(1);
                                    r_qcnt[w_ch] <= r_qcnt[w_ch] + QW'(1);
                                end
                                r_woff[w_ch] <= '0;
                                r_rej[w_ch]  <= 1'b0;
                            end
                            r_busy <= 1'b0; r_ovalid <= 1'b1;
                        end else if (r_qcnt[w_ch] == '0) begin
                            res.status   = ST_EMPTY;
                            res.last_out = 1'b1;
                            r_busy <= 1'b0; r_ovalid <= 1'b1;
                        end else begin
                            r_phase <= 2'd1;
                        end
                        r_res <= res;
                    end
                    2'd1: begin
                        r_len   <= w_len_rd;
                        r_dzero <= !(32'(w_off) < 32'(MSG_BYTES));
                        r_rlast <= w_last;
                        if (w_last) begin
                            r_roff[w_ch] <= '0;
                            r_head[w_ch] <= (r_head[w_ch] == SW'(SLOTS - 1)) ?
                                            '0 : r_head[w_ch] + SW'(1);
                            r_qcnt[w_ch] <= r_qcnt[w_ch] - QW'(1);
                        end else begin
                            r_roff[w_ch] <= w_off + (OW+1)'(1);
                        end
                        r_phase <= 2'd2;
                    end
                    default: begin
                        r_res.status     <= ST_OK;
                        r_res.data_out   <= r_dzero ? 8'd0 : w_byte_rd;
                        r_res.last_out   <= r_rlast;
                        r_res.msg_length <= 9'(r_len);
                        r_busy <= 1'b0; r_ovalid <= 1'b1;
                        r_phase <= 2'd0;
                    end
                endcase
            end
        end
    end
endmodule
`default_nettype wire

// ===== rtl/clearable_multi_channel_message_fifo.sv =====
// ----------------------------------------------------------------------------
// clearable_multi_channel_message_fifo
// per-channel circular queues of variable-length byte messages
// ----------------------------------------------------------------------------
// Each transaction gives one result. Writes, clears, no-ops, bad-channel
// transactions and empty reads end in the first phase of the execution
// unit; other reads go on through the chained length and byte ram reads.
// A two-entry input queue takes new transactions while a result waits.
`default_nettype none
module clearable_multi_channel_message_fifo
    import cmcmf_pkg::*;
#(
    parameter int unsigned CHANNELS  = CHANNELS_DEF,
    parameter int unsigned SLOTS     = SLOTS_DEF,
    parameter int unsigned MSG_BYTES = MSG_BYTES_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_stall,
    input  wire logic [1:0] i_cmd,
    input  wire logic [1:0] i_channel,
    input  wire logic [7:0] i_data_in,
    input  wire logic       i_last_in,
    output logic            o_valid,
    input  wire logic       i_stall,
    output logic [2:0]      o_status,
    output logic [7:0]      o_data_out,
    output logic            o_last_out,
    output logic [8:0]      o_msg_length
);
    t_item   w_in;
    t_item   w_q;
    logic    w_qv;
    logic    w_take;
    t_result w_res;

    assign w_in = '{cmd: i_cmd, channel: i_channel, data_in: i_data_in, last_in: i_last_in};

    cmcmf_front u_front (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_stall(o_stall),
        .i_item (w_in),
        .o_valid(w_qv),
        .i_take (w_take),
        .o_item (w_q)
    );

    cmcmf_back #(.CHANNELS(CHANNELS), .SLOTS(SLOTS), .MSG_BYTES(MSG_BYTES)) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_qv),
        .o_take  (w_take),
        .i_item  (w_q),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_result(w_res)
    );

    assign o_status     = w_res.status;
    assign o_data_out   = w_res.data_out;
    assign o_last_out   = w_res.last_out;
    assign o_msg_length = w_res.msg_length;

`ifndef SYNTHESIS
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_status))
        else $error("result changed under stall");
    a_empty_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == ST_EMPTY |-> o_last_out && o_msg_length == 9'd0)
        else $error("empty read without last");
    a_len_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == ST_OK && o_msg_length != 9'd0 |->
        32'(o_msg_length) <= 32'(MSG_BYTES))
        else $error("bad read result");
`endif
endmodule
`default_nettype wire

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// checks the multi-channel message fifo against a behavioral queue model
// under random idling on both sides and a long receiver hold-off
// ----------------------------------------------------------------------------
`default_nettype none
module tb_top;
    import cmcmf_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NCH   = 4;
    localparam int NSLOT = 8;
    localparam int NBYTE = 256;
    localparam int WATCHDOG_LIMIT = 20000;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_valid = 1'b0;
    logic       o_stall;
    logic [1:0] i_cmd = CMD_NOP;
    logic [1:0] i_channel = '0;
    logic [7:0] i_data_in = '0;
    logic       i_last_in = 1'b0;
    logic       o_valid;
    logic       i_stall = 1'b0;
    logic [2:0] o_status;
    logic [7:0] o_data_out;
    logic       o_last_out;
    logic [8:0] o_msg_length;

    clearable_multi_channel_message_fifo u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_cmd(i_cmd), .i_channel(i_channel), .i_data_in(i_data_in),
        .i_last_in(i_last_in), .o_valid(o_valid), .i_stall(i_stall),
        .o_status(o_status), .o_data_out(o_data_out), .o_last_out(o_last_out),
        .o_msg_length(o_msg_length)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // queue model state
    logic [7:0] msg_mem [NCH][NSLOT][NBYTE];
    logic [8:0] len_mem [NCH][NSLOT];
    int unsigned head_q [NCH];
    int unsigned tail_q [NCH];
    int unsigned count_q [NCH];
    int unsigned wr_off [NCH];
    int unsigned rd_off [NCH];
    bit          wr_rej [NCH];

    t_result expected_results [$];
    int n_sent, n_recv, n_mismatch, n_reads_ok, n_drops;
    bit idle_en = 1'b1;
    int hold_len = 0;
    int quiet_cycles = 0;

    function automatic t_result predict_fifo(t_item it);
        t_result r;
        int unsigned ch, off, h, len;
        bit full, too_long;
        r = '0;
        ch = it.channel;
        if (it.cmd == CMD_NOP) return r;
        if (ch >= NCH) begin
            r.status = ST_BAD_CH;
            return r;
        end
        case (it.cmd)
            CMD_WRITE: begin
                off = wr_off[ch];
                full = count_q[ch] >= NSLOT;
                too_long = off >= NBYTE;
                if (full) wr_rej[ch] = 1'b1;
                else if (!too_long) msg_mem[ch][tail_q[ch]][off] = it.data_in;
                if (off <= NBYTE) off++;
                if (!it.last_in) begin
                    wr_off[ch] = off;
                    r.status = full ? ST_FULL : (too_long ? ST_TOO_LONG : ST_OK);
                end else begin
                    if (full || wr_rej[ch]) r.status = ST_FULL;
                    else if (off > NBYTE) r.status = ST_TOO_LONG;
                    else begin
                        len_mem[ch][tail_q[ch]] = off[8:0];
                        tail_q[ch] = (tail_q[ch] + 1) % NSLOT;
                        count_q[ch]++;
                    end
                    wr_off[ch] = 0;
                    wr_rej[ch] = 1'b0;
                end
            end
            CMD_READ: begin
                if (count_q[ch] == 0) begin
                    r.status = ST_EMPTY;
                    r.last_out = 1'b1;
                end else begin
                    h = head_q[ch];
                    len = len_mem[ch][h];
                    off = rd_off[ch];
                    r.data_out = (off < NBYTE) ? msg_mem[ch][h][off] : 8'd0;
                    r.msg_length = len[8:0];
                    r.last_out = (off + 1) >= len;
                    if (r.last_out) begin
                        rd_off[ch] = 0;
                        head_q[ch] = (h + 1) % NSLOT;
                        count_q[ch]--;
                    end else begin
                        rd_off[ch] = off + 1;
                    end
                end
            end
            default: begin
                head_q[ch] = 0;
                tail_q[ch] = 0;
                count_q[ch] = 0;
                wr_off[ch] = 0;
                rd_off[ch] = 0;
                wr_rej[ch] = 1'b0;
            end
        endcase
        return r;
    endfunction

    task automatic send_item(logic [1:0] cmd, logic [1:0] ch, logic [7:0] d, logic lst);
        t_item it;
        while (idle_en && $urandom_range(99) < 12) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        it.cmd = cmd;
        it.channel = ch;
        it.data_in = d;
        it.last_in = lst;
        i_valid <= 1'b1;
        i_cmd <= cmd;
        i_channel <= ch;
        i_data_in <= d;
        i_last_in <= lst;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        expected_results.push_back(predict_fifo(it));
        n_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_message(logic [1:0] ch, int len);
        for (int k = 0; k < len; k++)
            send_item(CMD_WRITE, ch, 8'($urandom_range(255)), k == len - 1);
    endtask

    task automatic drain_quiet();
        i_valid <= 1'b0;
        while (expected_results.size() != 0) @(negedge i_clk);
        repeat (10) @(negedge i_clk);
    endtask

    // receiver stall
    always @(negedge i_clk) begin
        if (hold_len > 0) begin
            i_stall <= 1'b1;
            hold_len <= hold_len - 1;
        end else i_stall <= idle_en && ($urandom_range(99) < 12);
    end

    // result checker
    always @(posedge i_clk) begin
        t_result exp_r, act;
        if (i_rst_n && o_valid && !i_stall) begin
            act = '{o_status, o_data_out, o_last_out, o_msg_length};
            n_recv++;
            if (expected_results.size() == 0) begin
                n_mismatch++;
                if (n_mismatch <= 10) $display("unexpected result %p", act);
            end else begin
                exp_r = expected_results.pop_front();
                if (act !== exp_r) begin
                    n_mismatch++;
                    if (n_mismatch <= 10)
                        $display("mismatch: expected %p actual %p", exp_r, act);
                end
                if (exp_r.status == ST_OK && exp_r.msg_length != 0) n_reads_ok++;
                if (exp_r.status == ST_FULL || exp_r.status == ST_TOO_LONG) n_drops++;
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || !i_rst_n)
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog expired");
            $display("Some tests failed");
            $finish;
        end else quiet_cycles <= quiet_cycles + 1;
    end

    task automatic test_basic_ops();
        send_item(CMD_READ, 0, 8'h00, 0);
        send_item(CMD_NOP, 3, 8'hff, 1);
        send_item(CMD_WRITE, 1, 8'h00, 1);
        send_item(CMD_WRITE, 1, 8'hff, 0);
        send_item(CMD_WRITE, 1, 8'ha5, 1);
        send_item(CMD_READ, 1, 8'hff, 1);
        send_item(CMD_READ, 1, 8'h00, 0);
        send_item(CMD_READ, 1, 8'h00, 0);
        send_item(CMD_READ, 1, 8'h00, 0);
        send_item(CMD_READ, 1, 8'h00, 0);
        send_item(CMD_WRITE, 3, 8'h5a, 0);
        send_item(CMD_CLEAR, 3, 8'h00, 0);
        send_item(CMD_READ, 3, 8'h00, 0);
        send_item(CMD_WRITE, 3, 8'h11, 1);
        send_item(CMD_READ, 3, 8'h00, 0);
        drain_quiet();
    endtask

    task automatic test_full_queue();
        for (int m = 0; m < NSLOT; m++) send_message(2, 1 + (m % 3));
        send_item(CMD_WRITE, 2, 8'h77, 0);
        send_item(CMD_READ, 2, 8'h00, 0);
        send_item(CMD_WRITE, 2, 8'h78, 1);
        send_item(CMD_WRITE, 2, 8'h79, 1);
        send_item(CMD_WRITE, 2, 8'h7a, 1);
        send_item(CMD_CLEAR, 2, 8'h00, 0);
        drain_quiet();
    endtask

    task automatic test_long_messages();
        send_message(0, NBYTE);
        send_message(0, NBYTE + 2);
        for (int k = 0; k < 20; k++) send_item(CMD_READ, 0, 8'h00, 0);
        send_item(CMD_CLEAR, 0, 8'h00, 0);
        drain_quiet();
    endtask

    task automatic test_backpressure();
        int hold;
        hold = 60;
        idle_en = 1'b0;
        hold_len <= hold;
        for (int k = 0; k < 30; k++) send_item(CMD_READ, 1, 8'h00, 0);
        drain_quiet();
    endtask

    task automatic test_random_traffic();
        int sel, ch, len;
        while (n_sent < 740) begin
            idle_en = !(n_sent >= 600 && n_sent < 690);
            sel = $urandom_range(99);
            ch = $urandom_range(3);
            if (sel < 40) begin
                len = ($urandom_range(19) == 0) ? $urandom_range(NBYTE + 2, 100)
                                                : $urandom_range(6, 1);
                send_message(2'(ch), len);
            end else if (sel < 85) begin
                send_item(CMD_READ, 2'(ch), 8'($urandom_range(255)), 1'($urandom_range(1)));
            end else if (sel < 89) begin
                send_item(CMD_CLEAR, 2'(ch), 8'($urandom_range(255)), 1'($urandom_range(1)));
            end else if (sel < 93) begin
                send_item(CMD_NOP, 2'(ch), 8'($urandom_range(255)), 1'($urandom_range(1)));
            end else begin
                send_item(CMD_WRITE, 2'(ch), 8'($urandom_range(255)), 1'($urandom_range(1)));
            end
        end
        idle_en = 1'b1;
        drain_quiet();
    endtask

    initial begin
        for (int c = 0; c < NCH; c++) begin
            head_q[c] = 0; tail_q[c] = 0; count_q[c] = 0;
            wr_off[c] = 0; rd_off[c] = 0; wr_rej[c] = 1'b0;
        end
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_basic_ops();
        test_full_queue();
        test_long_messages();
        test_backpressure();
        test_random_traffic();
        $display("sent %0d transactions, %0d results, %0d message bytes read, %0d drops/rejects",
                 n_sent, n_recv, n_reads_ok, n_drops);
        if (n_mismatch == 0 && expected_results.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("%0d mismatches, %0d results missing", n_mismatch,
                     expected_results.size());
            $display("Some tests failed");
        end
        $finish;
    end
endmodule
`default_nettype wire
